// File: src/arqw_pkg.sv
// Shared types and constants for the ARQ window retransmit table.
`default_nettype none
package arqw_pkg;
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_ACK = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [3:0] EV_SENT = 4'd0;
	localparam logic [3:0] EV_WIN_FULL = 4'd1;
	localparam logic [3:0] EV_UNTRACKED = 4'd2;
	localparam logic [3:0] EV_RESEND = 4'd3;
	localparam logic [3:0] EV_GAVE_UP = 4'd4;
	localparam logic [3:0] EV_ACK_OK = 4'd5;
	localparam logic [3:0] EV_ACK_LATE = 4'd6;
	localparam logic [3:0] EV_ACK_NONE = 4'd7;
	localparam logic [3:0] EV_IDLE = 4'd8;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_RETRIES = 2'd2;

	typedef struct packed {
		logic        valid;
		logic        sender;
		logic        receiver;
		logic [31:0] seq;
		logic [31:0] deadline;
		logic [2:0]  retries;
	} entry_t;

	typedef struct packed {
		logic [3:0]  ev;
		logic        sender;
		logic        receiver;
		logic [31:0] seq;
	} result_t;
endpackage
`default_nettype wire

// File: src/arqw_cell.sv
// One table slot of the rotating retransmit ring.
`default_nettype none
module arqw_cell import arqw_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    shift,
	input  entry_t d,
	output entry_t q
);
	logic valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end
endmodule
`default_nettype wire

// File: src/arq_window_retransmit_table_core.sv
// Top level: ARQ sliding-window retransmit tracker built on a ring of slot cells.
// Every accepted send, every ack and every tick rotates the ring once, one slot per cycle
// at the head cell; a flush state then emits the final result.
// A refused send goes straight to the flush; operation 3 is taken with no result.
// Output stalls hold the ring. arst_n clears the slot valid bits, sequence counters,
// the time counter and the registers (window 4, timeout 200, retries 4).
`default_nettype none
module arq_window_retransmit_table_core import arqw_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // sender, receiver, ack_seq[31:0], zero fill
	input  wire  [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // out_sender, out_receiver, out_seq[31:0], zero fill
	output logic [3:0]  m_tuser,   // event_res
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_idx,
	input  wire  [15:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	logic [4:0] window_q;
	logic [15:0] timeout_q;
	logic [2:0] retry_lim_q;
	logic [31:0] time_q;
	logic [31:0] next_seq_q [4];
	logic [31:0] base_seq_q [4];

	logic [1:0] op_q;
	logic s_q, r_q;
	logic [31:0] aseq_q;
	logic found_q;
	logic [IDX_W-1:0] cnt_q;
	logic [NRES_W-1:0] nres_q;
	logic pend_valid_q;
	result_t pend_q;
	logic out_valid_q;
	logic out_last_q;
	result_t out_q;

	entry_t cell_q [TABLE_ENTRIES];
	entry_t cell_d [TABLE_ENTRIES];
	entry_t head, head_next;
	logic hit_found, tick_res, on_time, out_free, step, res_emit;
	logic [31:0] ack_gap;
	result_t tick_r;

	logic in_s, in_r;
	logic [1:0] in_p;
	logic [31:0] in_seq;
	logic win_full;

	assign out_free = !out_valid_q || m_tready;
	assign step = (state_q == ST_SCAN) && out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign res_emit = out_free && (state_q == ST_FLUSH
		|| (state_q == ST_SCAN && tick_res && pend_valid_q));

	assign in_s = s_tdata[0];
	assign in_r = s_tdata[1];
	assign in_p = {in_s, in_r};
	assign in_seq = next_seq_q[in_p];
	assign win_full = (in_seq - base_seq_q[in_p]) >= {27'd0, window_q};

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			if (gi == TABLE_ENTRIES - 1) begin : g_tail
				assign cell_d[gi] = head_next;
			end else begin : g_mid
				assign cell_d[gi] = cell_q[gi+1];
			end
			arqw_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (step),
				.d      (cell_d[gi]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	assign head = cell_q[0];
	assign ack_gap = head.deadline - time_q;
	assign on_time = !ack_gap[31];
	always_comb begin
		logic [31:0] late;
		late = head.deadline - time_q;
		head_next = head;
		hit_found = 1'b0;
		tick_res = 1'b0;
		tick_r = '{ev: EV_RESEND, sender: head.sender, receiver: head.receiver, seq: head.seq};
		unique case (op_q)
			OP_SEND: begin
				if (!found_q && !head.valid) begin
					head_next = '{valid: 1'b1, sender: s_q, receiver: r_q,
						seq: pend_q.seq, deadline: time_q + {16'd0, timeout_q}, retries: 3'd0};
					hit_found = 1'b1;
				end
			end
			OP_ACK: begin
				if (!found_q && head.valid && head.sender == s_q && head.receiver == r_q
					&& head.seq == aseq_q) begin
					head_next.valid = 1'b0;
					hit_found = 1'b1;
				end
			end
			OP_TICK: begin
				late = time_q - head.deadline;
				if (nres_q < NRES_W'(MAX_RESULTS) && head.valid && !late[31]) begin
					tick_res = 1'b1;
					if (head.retries < retry_lim_q) begin
						head_next.deadline = time_q + {16'd0, timeout_q};
						head_next.retries = head.retries + 3'd1;
					end else begin
						head_next.valid = 1'b0;
						tick_r.ev = EV_GAVE_UP;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 5'd4;
			timeout_q <= 16'd200;
			retry_lim_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW:  window_q <= cfg_data[4:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_RETRIES: retry_lim_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q <= '0;
			for (int k = 0; k < 4; k++) begin
				next_seq_q[k] <= '0;
				base_seq_q[k] <= '0;
			end
			found_q <= 1'b0;
			cnt_q <= '0;
			nres_q <= '0;
			pend_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						found_q <= 1'b0;
						cnt_q <= '0;
						nres_q <= '0;
						unique case (s_tuser)
							OP_SEND: begin
								pend_valid_q <= 1'b1;
								if (win_full) begin
									state_q <= ST_FLUSH;
								end else begin
									next_seq_q[in_p] <= in_seq + 32'd1;
									state_q <= ST_SCAN;
								end
							end
							OP_ACK: begin
								pend_valid_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							OP_TICK: begin
								pend_valid_q <= 1'b0;
								time_q <= time_q + 32'd1;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						if (hit_found) begin
							found_q <= 1'b1;
							if (op_q == OP_ACK) begin
								base_seq_q[{s_q, r_q}] <= aseq_q + 32'd1;
							end
						end
						if (tick_res) begin
							if (pend_valid_q) begin
								out_last_q <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							nres_q <= nres_q + NRES_W'(1);
						end
						if (cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q <= s_tuser;
					s_q <= in_s;
					r_q <= in_r;
					aseq_q <= s_tdata[33:2];
					pend_q.sender <= in_s;
					pend_q.receiver <= in_r;
					if (s_tuser == OP_ACK) begin
						pend_q.ev <= EV_ACK_NONE;
						pend_q.seq <= s_tdata[33:2];
					end else begin
						pend_q.ev <= win_full ? EV_WIN_FULL : EV_UNTRACKED;
						pend_q.seq <= in_seq;
					end
				end
			end
			ST_SCAN: begin
				if (out_free) begin
					if (hit_found) begin
						if (op_q == OP_SEND) begin
							pend_q.ev <= EV_SENT;
						end else begin
							pend_q.ev <= on_time ? EV_ACK_OK : EV_ACK_LATE;
						end
					end
					if (tick_res) begin
						out_q <= pend_q;
						pend_q <= tick_r;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_q <= pend_valid_q ? pend_q
						: '{ev: EV_IDLE, sender: 1'b0, receiver: 1'b0, seq: 32'd0};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.ev;
	assign m_tdata = {6'd0, out_q.seq, out_q.receiver, out_q.sender};
	assign m_tlast = out_last_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q) else $error("pending result left in idle");
	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_W'(MAX_RESULTS)) else $error("too many tick results");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH && out_free |=> out_valid_q && out_last_q)
		else $error("flush did not emit final result");
`endif
endmodule
`default_nettype wire
